// ===== rtl/core/euler_angles_to_pose_matrix_assert.svh =====
// assertion macros shared by the euler pose block
`ifndef EULER_ANGLES_TO_POSE_MATRIX_ASSERT_SVH
`define EULER_ANGLES_TO_POSE_MATRIX_ASSERT_SVH

// same-cycle implication, checked out of reset
`define EAPM_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("eapm: same-cycle check failed");

// next-cycle implication, checked out of reset
`define EAPM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("eapm: next-cycle check failed");

`endif

// ===== rtl/core/eapm_pkg.sv =====
// types, constants and arithmetic helpers of the euler pose block
`timescale 1ns / 1ps
`default_nettype none
package eapm_pkg;

	localparam int ANGLE_BITS     = 16;
	localparam int COEF_FRAC_BITS = 16;
	localparam int COEF_W         = COEF_FRAC_BITS + 2;
	localparam int RND_SH         = 30 - COEF_FRAC_BITS;

	localparam int CORDIC_STEPS = 30;
	localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
	localparam int MAT_LAT      = 5;
	localparam int TOTAL_LAT    = CORDIC_LAT + MAT_LAT;
	localparam int N_ENTRY      = 9;

	localparam int XW = 35;
	localparam int ZW = 33;
	localparam int QW = 32;
	localparam int SW = QW + 1;

	localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(64'sd2608131496);
	localparam logic signed [QW-1:0] ONE_Q30     = QW'(64'sd1 << 30);
	localparam logic signed [QW-1:0] NEG_ONE_Q30 = -ONE_Q30;
	localparam logic signed [63:0]   HALF_Q30    = 64'sd1 << 29;
	localparam logic signed [SW:0]   COEF_HALF   =
		(RND_SH == 0) ? '0 : (SW+1)'(64'sd1 << ((RND_SH == 0) ? 0 : RND_SH - 1));
	localparam logic signed [COEF_W-1:0] COEF_ONE     = COEF_W'(64'sd1 << COEF_FRAC_BITS);
	localparam logic signed [COEF_W-1:0] COEF_NEG_ONE = -COEF_ONE;

	localparam int ATAN_TBL [CORDIC_STEPS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81, 40, 20,
		10, 5, 2, 1
	};

	typedef enum logic [1:0] {
		CONV_TB_EXT = 2'd0,
		CONV_TB_INT = 2'd1,
		CONV_EU_EXT = 2'd2,
		CONV_EU_INT = 2'd3
	} conv_t;

	typedef enum logic [3:0] {
		OP_ZERO, OP_ONE,
		OP_SF, OP_CF, OP_ST, OP_CT, OP_SP, OP_CP,
		OP_NSF, OP_NCF, OP_NST, OP_NSP, OP_NCP
	} op_t;

	typedef struct packed {
		op_t  a;
		op_t  b;
		op_t  c;
		logic sub;
		op_t  d;
		op_t  e;
	} term_t;

	typedef struct packed {
		logic signed [QW-1:0] sf;
		logic signed [QW-1:0] cf;
		logic signed [QW-1:0] st;
		logic signed [QW-1:0] ct;
		logic signed [QW-1:0] sp;
		logic signed [QW-1:0] cp;
	} trig_t;

	function automatic logic signed [QW-1:0] clamp_q30(input logic signed [XW-1:0] v);
		logic signed [QW-1:0] r;
		if (v > XW'(ONE_Q30))
			r = ONE_Q30;
		else if (v < XW'(NEG_ONE_Q30))
			r = NEG_ONE_Q30;
		else
			r = v[QW-1:0];
		return r;
	endfunction

	// q30 product, halves toward plus infinity
	function automatic logic signed [QW-1:0] mul_q30(input logic signed [QW-1:0] a,
		input logic signed [QW-1:0] b);
		logic signed [63:0] p;
		p = (64'(a) * 64'(b)) + HALF_Q30;
		return QW'(p >>> 30);
	endfunction

	function automatic logic signed [COEF_W-1:0] to_coef(input logic signed [SW-1:0] v);
		logic signed [SW:0] r;
		r = ((SW+1)'(v) + COEF_HALF) >>> RND_SH;
		if (r > (SW+1)'(COEF_ONE))
			return COEF_ONE;
		else if (r < (SW+1)'(COEF_NEG_ONE))
			return COEF_NEG_ONE;
		else
			return r[COEF_W-1:0];
	endfunction

	function automatic logic signed [QW-1:0] pick(input op_t op, input trig_t t);
		logic signed [QW-1:0] r;
		unique case (op)
			OP_ZERO: r = '0;
			OP_ONE:  r = ONE_Q30;
			OP_SF:   r = t.sf;
			OP_CF:   r = t.cf;
			OP_ST:   r = t.st;
			OP_CT:   r = t.ct;
			OP_SP:   r = t.sp;
			OP_CP:   r = t.cp;
			OP_NSF:  r = -t.sf;
			OP_NCF:  r = -t.cf;
			OP_NST:  r = -t.st;
			OP_NSP:  r = -t.sp;
			OP_NCP:  r = -t.cp;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic term_t mk(input op_t a, input op_t b, input op_t c, input logic sub,
		input op_t d, input op_t e);
		term_t t;
		t.a = a; t.b = b; t.c = c; t.sub = sub; t.d = d; t.e = e;
		return t;
	endfunction

	// entry = (a*b)*c +/- d*e
	function automatic term_t term_sel(input conv_t conv, input logic [3:0] k);
		term_t t;
		t = mk(OP_ZERO, OP_ZERO, OP_ZERO, 1'b0, OP_ZERO, OP_ZERO);
		unique case (conv)
			CONV_TB_EXT: begin
				case (k)
					4'd0: t = mk(OP_CT, OP_CF, OP_ONE, 1'b0, OP_ZERO, OP_ZERO);
					4'd1: t = mk(OP_SP, OP_ST, OP_CF, 1'b1, OP_CP, OP_SF);
					4'd2: t = mk(OP_CP, OP_CT, OP_CF, 1'b0, OP_SP, OP_SF);
					4'd3: t = mk(OP_CT, OP_SF, OP_ONE, 1'b0, OP_ZERO, OP_ZERO);
					4'd4: t = mk(OP_SP, OP_ST, OP_SF, 1'b0, OP_CP, OP_CF);
					4'd5: t = mk(OP_CP, OP_ST, OP_SF, 1'b1, OP_SP, OP_CF);
					4'd6: t = mk(OP_NST, OP_ONE, OP_ONE, 1'b0, OP_ZERO, OP_ZERO);
					4'd7: t = mk(OP_SP, OP_CT, OP_ONE, 1'b0, OP_ZERO, OP_ZERO);
					4'd8: t = mk(OP_CP, OP_CT, OP_ONE, 1'b0, OP_ZERO, OP_ZERO);
					default: ;
				endcase
			end
			CONV_TB_INT: begin
				case (k)
					4'd0: t = mk(OP_CF, OP_CT, OP_ONE, 1'b0, OP_ZERO, OP_ZERO);
					4'd1: t = mk(OP_SF, OP_CT, OP_ONE, 1'b0, OP_ZERO, OP_ZERO);
					4'd2: t = mk(OP_NST, OP_ONE, OP_ONE, 1'b0, OP_ZERO, OP_ZERO);
					4'd3: t = mk(OP_CF, OP_ST, OP_SP, 1'b1, OP_SF, OP_CP);
					4'd4: t = mk(OP_SF, OP_ST, OP_SP, 1'b0, OP_CF, OP_CP);
					4'd5: t = mk(OP_CT, OP_SP, OP_ONE, 1'b0, OP_ZERO, OP_ZERO);
					4'd6: t = mk(OP_CF, OP_ST, OP_CP, 1'b0, OP_SF, OP_SP);
					4'd7: t = mk(OP_SF, OP_ST, OP_CP, 1'b1, OP_CF, OP_SP);
					4'd8: t = mk(OP_CT, OP_CP, OP_ONE, 1'b0, OP_ZERO, OP_ZERO);
					default: ;
				endcase
			end
			CONV_EU_EXT: begin
				case (k)
					4'd0: t = mk(OP_CP, OP_CT, OP_CF, 1'b1, OP_SP, OP_SF);
					4'd1: t = mk(OP_SP, OP_CT, OP_CF, 1'b0, OP_CP, OP_SF);
					4'd2: t = mk(OP_NST, OP_CF, OP_ONE, 1'b0, OP_ZERO, OP_ZERO);
					4'd3: t = mk(OP_NCP, OP_CT, OP_SF, 1'b1, OP_SP, OP_CF);
					4'd4: t = mk(OP_NSP, OP_CT, OP_SF, 1'b0, OP_CP, OP_CF);
					4'd5: t = mk(OP_ST, OP_SF, OP_ONE, 1'b0, OP_ZERO, OP_ZERO);
					4'd6: t = mk(OP_CP, OP_ST, OP_ONE, 1'b0, OP_ZERO, OP_ZERO);
					4'd7: t = mk(OP_SP, OP_ST, OP_ONE, 1'b0, OP_ZERO, OP_ZERO);
					4'd8: t = mk(OP_CT, OP_ONE, OP_ONE, 1'b0, OP_ZERO, OP_ZERO);
					default: ;
				endcase
			end
			CONV_EU_INT: begin
				case (k)
					4'd0: t = mk(OP_CF, OP_CT, OP_CP, 1'b1, OP_SF, OP_SP);
					4'd1: t = mk(OP_SF, OP_CT, OP_CP, 1'b0, OP_CF, OP_SP);
					4'd2: t = mk(OP_NST, OP_CP, OP_ONE, 1'b0, OP_ZERO, OP_ZERO);
					4'd3: t = mk(OP_NCF, OP_CT, OP_SP, 1'b1, OP_SF, OP_CP);
					4'd4: t = mk(OP_NSF, OP_CT, OP_SP, 1'b0, OP_CF, OP_CP);
					4'd5: t = mk(OP_ST, OP_SP, OP_ONE, 1'b0, OP_ZERO, OP_ZERO);
					4'd6: t = mk(OP_CF, OP_ST, OP_ONE, 1'b0, OP_ZERO, OP_ZERO);
					4'd7: t = mk(OP_SF, OP_ST, OP_ONE, 1'b0, OP_ZERO, OP_ZERO);
					4'd8: t = mk(OP_CT, OP_ONE, OP_ONE, 1'b0, OP_ZERO, OP_ZERO);
					default: ;
				endcase
			end
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/eapm_cordic.sv =====
// pipelined cordic sine and cosine of one binary angle, q30 results
`timescale 1ns / 1ps
`default_nettype none
module eapm_cordic import eapm_pkg::*; (
	input  wire logic                  clk,
	input  wire logic [ANGLE_BITS-1:0] angle,
	output logic signed [QW-1:0]       sin_val,
	output logic signed [QW-1:0]       cos_val
);

	logic [31:0] full;
	logic signed [XW-1:0] x_s [CORDIC_STEPS+1];
	logic signed [XW-1:0] y_s [CORDIC_STEPS+1];
	logic signed [ZW-1:0] z_s [CORDIC_STEPS+1];
	logic [1:0] quad_s [CORDIC_STEPS+1];
	logic       axis_s [CORDIC_STEPS+1];
	logic signed [QW-1:0] c_rnd, s_rnd, c_val, s_val;

	assign full = {angle, {(32-ANGLE_BITS){1'b0}}};

	always_ff @(posedge clk) begin
		x_s[0]    <= CORDIC_GAIN;
		y_s[0]    <= '0;
		z_s[0]    <= ZW'(full[29:0]);
		quad_s[0] <= full[31:30];
		axis_s[0] <= (full[29:0] == 30'd0);
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [XW-1:0] dx, dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (!z_s[i][ZW-1]) begin
				x_s[i+1] <= x_s[i] - dx;
				y_s[i+1] <= y_s[i] + dy;
				z_s[i+1] <= z_s[i] - ZW'(ATAN_TBL[i]);
			end else begin
				x_s[i+1] <= x_s[i] + dx;
				y_s[i+1] <= y_s[i] - dy;
				z_s[i+1] <= z_s[i] + ZW'(ATAN_TBL[i]);
			end
			quad_s[i+1] <= quad_s[i];
			axis_s[i+1] <= axis_s[i];
		end
	end

	// q32 to q30 with rounding, exact on the axes
	always_comb begin
		c_rnd = clamp_q30((x_s[CORDIC_STEPS] + XW'(2)) >>> 2);
		s_rnd = clamp_q30((y_s[CORDIC_STEPS] + XW'(2)) >>> 2);
		c_val = axis_s[CORDIC_STEPS] ? ONE_Q30 : c_rnd;
		s_val = axis_s[CORDIC_STEPS] ? '0 : s_rnd;
	end

	always_ff @(posedge clk) begin
		unique case (quad_s[CORDIC_STEPS])
			2'd0: begin
				cos_val <= c_val;
				sin_val <= s_val;
			end
			2'd1: begin
				cos_val <= -s_val;
				sin_val <= c_val;
			end
			2'd2: begin
				cos_val <= -c_val;
				sin_val <= -s_val;
			end
			2'd3: begin
				cos_val <= s_val;
				sin_val <= -c_val;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/euler_angles_to_pose_matrix.sv =====
// top level of the euler pose block: angles and translation in, pose matrix out
//
// channel   signals                               handshake
// input     start busy angle_* shift_*            taken when start and not busy
// result    done m00..m22 trans_out_*             one cycle, marked by done
// config    cfg_valid cfg_ready cfg_data          written when valid and ready
//
// one item per cycle, busy is never raised
// each item passes through the cordic rotators and then the matrix products
// arst_n clears the pipeline valid bits and sets convention to zero
// the result side cannot stall, so the pipeline never holds
`timescale 1ns / 1ps
`default_nettype none
module euler_angles_to_pose_matrix import eapm_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [1:0]               cfg_data,
	input  wire logic [ANGLE_BITS-1:0]    angle_first,
	input  wire logic [ANGLE_BITS-1:0]    angle_second,
	input  wire logic [ANGLE_BITS-1:0]    angle_third,
	input  wire logic signed [31:0]       shift_x,
	input  wire logic signed [31:0]       shift_y,
	input  wire logic signed [31:0]       shift_z,
	output logic                          done,
	output logic signed [COEF_W-1:0]      m00,
	output logic signed [COEF_W-1:0]      m10,
	output logic signed [COEF_W-1:0]      m20,
	output logic signed [COEF_W-1:0]      m01,
	output logic signed [COEF_W-1:0]      m11,
	output logic signed [COEF_W-1:0]      m21,
	output logic signed [COEF_W-1:0]      m02,
	output logic signed [COEF_W-1:0]      m12,
	output logic signed [COEF_W-1:0]      m22,
	output logic signed [31:0]            trans_out_x,
	output logic signed [31:0]            trans_out_y,
	output logic signed [31:0]            trans_out_z
);

	`include "euler_angles_to_pose_matrix_assert.svh"

	conv_t conv_q;
	logic  vld_s [TOTAL_LAT];
	logic signed [31:0] tx_s [TOTAL_LAT];
	logic signed [31:0] ty_s [TOTAL_LAT];
	logic signed [31:0] tz_s [TOTAL_LAT];
	trig_t trig;

	logic signed [QW-1:0] a_s1 [N_ENTRY];
	logic signed [QW-1:0] b_s1 [N_ENTRY];
	logic signed [QW-1:0] c_s1 [N_ENTRY];
	logic signed [QW-1:0] d_s1 [N_ENTRY];
	logic signed [QW-1:0] e_s1 [N_ENTRY];
	logic                 sub_s1 [N_ENTRY];
	logic signed [QW-1:0] p_s2 [N_ENTRY];
	logic signed [QW-1:0] c_s2 [N_ENTRY];
	logic signed [QW-1:0] q_s2 [N_ENTRY];
	logic                 sub_s2 [N_ENTRY];
	logic signed [QW-1:0] t_s3 [N_ENTRY];
	logic signed [QW-1:0] q_s3 [N_ENTRY];
	logic                 sub_s3 [N_ENTRY];
	logic signed [SW-1:0] sum_s4 [N_ENTRY];
	logic signed [COEF_W-1:0] m_s5 [N_ENTRY];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_q <= CONV_TB_EXT;
		end else if (cfg_valid && cfg_ready) begin
			conv_q <= conv_t'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOTAL_LAT; i++) vld_s[i] <= 1'b0;
		end else begin
			vld_s[0] <= start && !busy;
			for (int i = 1; i < TOTAL_LAT; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		tx_s[0] <= shift_x;
		ty_s[0] <= shift_y;
		tz_s[0] <= shift_z;
		for (int i = 1; i < TOTAL_LAT; i++) begin
			tx_s[i] <= tx_s[i-1];
			ty_s[i] <= ty_s[i-1];
			tz_s[i] <= tz_s[i-1];
		end
	end

	eapm_cordic u_cordic_first (
		.clk     (clk),
		.angle   (angle_first),
		.sin_val (trig.sf),
		.cos_val (trig.cf)
	);

	eapm_cordic u_cordic_second (
		.clk     (clk),
		.angle   (angle_second),
		.sin_val (trig.st),
		.cos_val (trig.ct)
	);

	eapm_cordic u_cordic_third (
		.clk     (clk),
		.angle   (angle_third),
		.sin_val (trig.sp),
		.cos_val (trig.cp)
	);

	// operand selection, two products, third factor, sum, rounding
	always_ff @(posedge clk) begin
		for (int k = 0; k < N_ENTRY; k++) begin
			term_t ts;
			ts = term_sel(conv_q, 4'(k));
			a_s1[k]   <= pick(ts.a, trig);
			b_s1[k]   <= pick(ts.b, trig);
			c_s1[k]   <= pick(ts.c, trig);
			d_s1[k]   <= pick(ts.d, trig);
			e_s1[k]   <= pick(ts.e, trig);
			sub_s1[k] <= ts.sub;

			p_s2[k]   <= mul_q30(a_s1[k], b_s1[k]);
			q_s2[k]   <= mul_q30(d_s1[k], e_s1[k]);
			c_s2[k]   <= c_s1[k];
			sub_s2[k] <= sub_s1[k];

			t_s3[k]   <= mul_q30(p_s2[k], c_s2[k]);
			q_s3[k]   <= q_s2[k];
			sub_s3[k] <= sub_s2[k];

			sum_s4[k] <= sub_s3[k] ? (SW'(t_s3[k]) - SW'(q_s3[k]))
				: (SW'(t_s3[k]) + SW'(q_s3[k]));

			m_s5[k]   <= to_coef(sum_s4[k]);
		end
	end

	assign done        = vld_s[TOTAL_LAT-1];
	assign m00         = m_s5[0];
	assign m10         = m_s5[1];
	assign m20         = m_s5[2];
	assign m01         = m_s5[3];
	assign m11         = m_s5[4];
	assign m21         = m_s5[5];
	assign m02         = m_s5[6];
	assign m12         = m_s5[7];
	assign m22         = m_s5[8];
	assign trans_out_x = tx_s[TOTAL_LAT-1];
	assign trans_out_y = ty_s[TOTAL_LAT-1];
	assign trans_out_z = tz_s[TOTAL_LAT-1];

	`EAPM_ASSERT_NEXT(a_start_enters, start && !busy, vld_s[0])
	`EAPM_ASSERT_IMPL(a_done_has_item, done, $past(start, TOTAL_LAT))
	`EAPM_ASSERT_IMPL(a_m00_bound, done, m00 <= COEF_ONE && m00 >= COEF_NEG_ONE)
	`EAPM_ASSERT_IMPL(a_m22_bound, done, m22 <= COEF_ONE && m22 >= COEF_NEG_ONE)

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for the euler pose block: predicted matrices against the pipeline
`timescale 1ns / 1ps
module testbench;
	import eapm_pkg::*;

	typedef enum logic [1:0] {K_POSE, K_CONV, K_DRAIN} job_kind_t;

	typedef struct {
		job_kind_t             kind;
		logic [ANGLE_BITS-1:0] phi, theta, psi;
		logic signed [31:0]    tx, ty, tz;
		conv_t                 conv;
		bit                    calm;
	} job_t;

	typedef struct packed {
		logic [8:0][COEF_W-1:0] m;
		logic [2:0][31:0]       tr;
	} pose_t;

	localparam int CYCLE_LIMIT = 300000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic cfg_valid = 1'b0;
	logic [1:0] cfg_data = '0;
	logic [ANGLE_BITS-1:0] angle_first = '0, angle_second = '0, angle_third = '0;
	logic signed [31:0] shift_x = '0, shift_y = '0, shift_z = '0;
	logic busy, cfg_ready, done;
	logic signed [COEF_W-1:0] m00, m10, m20, m01, m11, m21, m02, m12, m22;
	logic signed [31:0] trans_out_x, trans_out_y, trans_out_z;

	job_t  jobs[$];
	pose_t poses_due[$];
	conv_t conv_now = CONV_TB_EXT;
	int gap = 0, settle = 0, n_poses = 0, n_writes = 0, n_fail = 0, cycles = 0;
	string entry_name[9] = '{"m00", "m10", "m20", "m01", "m11", "m21", "m02", "m12", "m22"};
	string trans_name[3] = '{"trans_out_x", "trans_out_y", "trans_out_z"};

	euler_angles_to_pose_matrix i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.angle_first(angle_first), .angle_second(angle_second), .angle_third(angle_third),
		.shift_x(shift_x), .shift_y(shift_y), .shift_z(shift_z),
		.done(done), .m00(m00), .m10(m10), .m20(m20), .m01(m01), .m11(m11), .m21(m21),
		.m02(m02), .m12(m12), .m22(m22),
		.trans_out_x(trans_out_x), .trans_out_y(trans_out_y), .trans_out_z(trans_out_z)
	);

	always #10 clk = ~clk;

	function automatic longint rshift(longint v, int s);
		if (s == 0)
			return v;
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clip(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic longint mul2(longint a, longint b);
		return rshift(a * b, 30);
	endfunction

	function automatic longint mul3(longint a, longint b, longint c);
		return mul2(mul2(a, b), c);
	endfunction

	// cordic rotator in q32 with quarter-turn fold, results in q30
	function automatic void trig_of(input logic [ANGLE_BITS-1:0] ang, output longint sn,
		output longint cs);
		logic [31:0] full;
		longint x, y, z, dx, dy, c, s, one;
		one = 64'sd1 <<< 30;
		full = 32'(ang) << (32 - ANGLE_BITS);
		x = longint'(CORDIC_GAIN);
		y = 0;
		z = longint'({34'd0, full[29:0]});
		if (full[29:0] == 0) begin
			c = one;
			s = 0;
		end else begin
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= ATAN_TBL[i];
				end else begin
					x += dx; y -= dy; z += ATAN_TBL[i];
				end
			end
			c = clip(rshift(x, 2), one);
			s = clip(rshift(y, 2), one);
		end
		case (full[31:30])
			2'd0: begin cs = c;  sn = s;  end
			2'd1: begin cs = -s; sn = c;  end
			2'd2: begin cs = -c; sn = -s; end
			default: begin cs = s; sn = -c; end
		endcase
	endfunction

	function automatic pose_t predict_pose(job_t j, conv_t cv);
		longint sf, cf, st, ct, sp, cp, r;
		longint e[9];
		pose_t p;
		trig_of(j.phi, sf, cf);
		trig_of(j.theta, st, ct);
		trig_of(j.psi, sp, cp);
		case (cv)
			CONV_TB_EXT: begin
				e[0] = mul2(ct, cf);
				e[1] = mul3(sp, st, cf) - mul2(cp, sf);
				e[2] = mul3(cp, ct, cf) + mul2(sp, sf);
				e[3] = mul2(ct, sf);
				e[4] = mul3(sp, st, sf) + mul2(cp, cf);
				e[5] = mul3(cp, st, sf) - mul2(sp, cf);
				e[6] = -st;
				e[7] = mul2(sp, ct);
				e[8] = mul2(cp, ct);
			end
			CONV_TB_INT: begin
				e[0] = mul2(cf, ct);
				e[1] = mul2(sf, ct);
				e[2] = -st;
				e[3] = mul3(cf, st, sp) - mul2(sf, cp);
				e[4] = mul3(sf, st, sp) + mul2(cf, cp);
				e[5] = mul2(ct, sp);
				e[6] = mul3(cf, st, cp) + mul2(sf, sp);
				e[7] = mul3(sf, st, cp) - mul2(cf, sp);
				e[8] = mul2(ct, cp);
			end
			CONV_EU_EXT: begin
				e[0] = mul3(cp, ct, cf) - mul2(sp, sf);
				e[1] = mul3(sp, ct, cf) + mul2(cp, sf);
				e[2] = mul2(-st, cf);
				e[3] = mul3(-cp, ct, sf) - mul2(sp, cf);
				e[4] = mul3(-sp, ct, sf) + mul2(cp, cf);
				e[5] = mul2(st, sf);
				e[6] = mul2(cp, st);
				e[7] = mul2(sp, st);
				e[8] = ct;
			end
			default: begin
				e[0] = mul3(cf, ct, cp) - mul2(sf, sp);
				e[1] = mul3(sf, ct, cp) + mul2(cf, sp);
				e[2] = mul2(-st, cp);
				e[3] = mul3(-cf, ct, sp) - mul2(sf, cp);
				e[4] = mul3(-sf, ct, sp) + mul2(cf, cp);
				e[5] = mul2(st, sp);
				e[6] = mul2(cf, st);
				e[7] = mul2(sf, st);
				e[8] = ct;
			end
		endcase
		for (int k = 0; k < 9; k++) begin
			r = clip(rshift(e[k], 30 - COEF_FRAC_BITS), 64'sd1 <<< COEF_FRAC_BITS);
			p.m[k] = COEF_W'(r);
		end
		p.tr[0] = j.tx;
		p.tr[1] = j.ty;
		p.tr[2] = j.tz;
		return p;
	endfunction

	// driver: jobs stay at the head of the queue until taken
	always @(posedge clk or negedge arst_n) begin
		logic nxt_start, nxt_cfg;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			nxt_start = start;
			nxt_cfg = cfg_valid;
			if (start && !busy) begin
				poses_due.push_back(predict_pose(jobs[0], conv_now));
				jobs.pop_front();
				n_poses++;
				nxt_start = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				conv_now = conv_t'(cfg_data);
				jobs.pop_front();
				n_writes++;
				nxt_cfg = 1'b0;
			end
			if (!nxt_start && !nxt_cfg) begin
				if (gap > 0)
					gap--;
				else if (jobs.size() > 0) begin
					case (jobs[0].kind)
						K_POSE: begin
							if (!jobs[0].calm && $urandom_range(0, 6) == 0)
								gap = $urandom_range(1, 9);
							else begin
								nxt_start = 1'b1;
								angle_first <= jobs[0].phi;
								angle_second <= jobs[0].theta;
								angle_third <= jobs[0].psi;
								shift_x <= jobs[0].tx;
								shift_y <= jobs[0].ty;
								shift_z <= jobs[0].tz;
							end
						end
						K_CONV: begin
							nxt_cfg = 1'b1;
							cfg_data <= jobs[0].conv;
						end
						default: begin
							if (poses_due.size() == 0) begin
								if (settle >= TOTAL_LAT + 4) begin
									jobs.pop_front();
									settle = 0;
								end else
									settle++;
							end
						end
					endcase
				end
			end
			start <= nxt_start;
			cfg_valid <= nxt_cfg;
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			n_fail++;
		end
	endtask

	// monitor
	always @(posedge clk) begin
		pose_t seen, want;
		if (arst_n && done) begin
			seen.m = {m22, m12, m02, m21, m11, m01, m20, m10, m00};
			seen.tr = {trans_out_z, trans_out_y, trans_out_x};
			if (poses_due.size() == 0) begin
				$error("result with no item outstanding");
				n_fail++;
			end else begin
				want = poses_due.pop_front();
				for (int k = 0; k < 9; k++)
					check_field(entry_name[k], 32'(want.m[k]), 32'(seen.m[k]));
				for (int k = 0; k < 3; k++)
					check_field(trans_name[k], want.tr[k], seen.tr[k]);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("** euler_angles_to_pose_matrix: FAILED **");
			$finish;
		end
	end

	task automatic add_pose(logic [ANGLE_BITS-1:0] a, b, c, logic signed [31:0] x, y, z,
		bit calm);
		job_t j;
		j.kind = K_POSE; j.phi = a; j.theta = b; j.psi = c;
		j.tx = x; j.ty = y; j.tz = z; j.conv = CONV_TB_EXT; j.calm = calm;
		jobs.push_back(j);
	endtask

	task automatic add_conv(conv_t cv);
		job_t j;
		j.kind = K_DRAIN; j.conv = cv; j.calm = 1'b0;
		jobs.push_back(j);
		j.kind = K_CONV;
		jobs.push_back(j);
	endtask

	function automatic logic [ANGLE_BITS-1:0] pick_angle();
		logic [ANGLE_BITS-1:0] q;
		q = ANGLE_BITS'($urandom_range(0, 3)) << (ANGLE_BITS - 2);
		case ($urandom_range(0, 5))
			0: return q;
			1: return q + ANGLE_BITS'($urandom_range(0, 4)) - ANGLE_BITS'(2);
			default: return ANGLE_BITS'($urandom);
		endcase
	endfunction

	function automatic logic signed [31:0] pick_shift();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			default: return $urandom;
		endcase
	endfunction

	localparam logic [ANGLE_BITS-1:0] QTR = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
	localparam logic [ANGLE_BITS-1:0] AMAX = '1;

	initial begin
		conv_t order[6];
		order = '{CONV_EU_INT, CONV_TB_INT, CONV_EU_EXT, CONV_TB_EXT, CONV_EU_INT, CONV_TB_EXT};
		// directed: axes, extremes, every convention
		add_pose('0, '0, '0, '0, '0, '0, 0);
		add_pose(QTR, QTR, QTR, 32'sh7fffffff, 32'sh80000000, -1, 0);
		add_pose(2 * QTR, 3 * QTR, AMAX, 32'sh80000000, 32'sh7fffffff, 1, 0);
		add_pose(AMAX, 1, QTR - 1, -1, -1, -1, 0);
		add_pose(3 * QTR + 1, 2 * QTR - 1, 2 * QTR + 1, 32'sh55555555, 32'shaaaaaaaa, 0, 0);
		for (int c = 3; c >= 0; c--) begin
			add_conv(conv_t'(c));
			add_pose(QTR, QTR / 2, 3 * QTR, 1, 2, 3, 0);
			add_pose(AMAX, QTR, 1, -5, 7, -9, 0);
			add_pose(QTR / 3, 5 * QTR / 3, 7 * QTR / 3, 0, 0, 0, 0);
		end
		// random phases, the fourth and the last without idling
		for (int ph = 0; ph < 6; ph++) begin
			add_conv(ph == 5 ? conv_t'($urandom_range(0, 3)) : order[ph]);
			for (int n = 0; n < 148; n++)
				add_pose(pick_angle(), pick_angle(), pick_angle(),
					pick_shift(), pick_shift(), pick_shift(), ph == 5 || ph == 3);
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		while (jobs.size() > 0 || start || cfg_valid)
			@(posedge clk);
		while (poses_due.size() > 0)
			@(posedge clk);
		repeat (TOTAL_LAT + 8) @(posedge clk);
		$display("%0d poses checked over %0d convention writes, axis and random angles",
			n_poses, n_writes);
		if (n_fail == 0)
			$display("** euler_angles_to_pose_matrix: PASSED **");
		else
			$display("** euler_angles_to_pose_matrix: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/eapm_pkg.sv
rtl/core/eapm_cordic.sv
rtl/core/euler_angles_to_pose_matrix.sv
dv/testbench.sv
